/* src/dfe_pkg.sv */
// ----------------------------------------------------------------------------
// Delimited frame extractor package
// Shared constants, result kinds and register indexes.
// ----------------------------------------------------------------------------
package dfe_pkg;

  localparam int MAX_DEPTH  = 16;
  localparam int RESULT_CAP = 16;
  localparam int LIMIT_CAP  = (MAX_DEPTH < RESULT_CAP) ? MAX_DEPTH : RESULT_CAP;
  localparam int ADDR_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIMIT_CAP + 1);

  localparam int BYTE_W  = 8;
  localparam int LIMIT_W = 5;
  localparam int INDEX_W = 4;
  localparam int REG_W   = 2;

  typedef logic [1:0]         kind_t;
  typedef logic [REG_W-1:0]   reg_index_t;

  localparam kind_t KIND_PAYLOAD = 2'd0;
  localparam kind_t KIND_EMPTY   = 2'd1;
  localparam kind_t KIND_DROPPED = 2'd2;

  localparam reg_index_t REG_START_VALUE = 2'd0;
  localparam reg_index_t REG_END_VALUE   = 2'd1;
  localparam reg_index_t REG_MAX_PAYLOAD = 2'd2;

  localparam logic [BYTE_W-1:0]  START_RESET = 8'd70;
  localparam logic [BYTE_W-1:0]  END_RESET   = 8'd57;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd13;

endpackage

/* src/dfe_if.sv */
// ----------------------------------------------------------------------------
// Delimited frame extractor channels
// Valid/ready interfaces for received bytes, results and register writes.
// ----------------------------------------------------------------------------
interface dfe_in_if import dfe_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface dfe_out_if import dfe_pkg::*;;
  logic               valid;
  logic               ready;
  kind_t              kind;
  logic [BYTE_W-1:0]  payload_byte;
  logic [INDEX_W-1:0] byte_index;
  logic               last;

  modport source (output valid, output kind, output payload_byte, output byte_index,
                  output last, input ready);
  modport sink (input valid, input kind, input payload_byte, input byte_index,
                input last, output ready);
endinterface

interface dfe_cfg_if import dfe_pkg::*;;
  logic              valid;
  logic              ready;
  reg_index_t        index;
  logic [BYTE_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* src/delimited_frame_extractor.sv */
// ----------------------------------------------------------------------------
// Delimited frame extractor
// Opens a frame on the start byte, stores payload bytes in a small RAM and
// replays them as results when the end byte arrives; an empty or over-long frame gives a single result.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                   Transfer
//  cfg      in   index, data                               valid & ready
//  rx       in   rx_byte                                   valid & ready
//  res      out  kind, payload_byte, byte_index, last      valid & ready
//
//  Bytes outside the end byte transfer one per cycle while res is not stalled.
//  An end byte after n payload bytes holds rx off while the payload RAM
//  is read out, one entry per cycle through its registered read port
//  unless the res channel stalls.
//  Reset is synchronous; it restores the register defaults and idles.
//  The cfg channel is always ready.
// ----------------------------------------------------------------------------
module delimited_frame_extractor import dfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  dfe_cfg_if.sink    cfg,
  dfe_in_if.sink     rx,
  dfe_out_if.source  res
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FRAME = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]         st;
  logic [BYTE_W-1:0]  start_value;
  logic [BYTE_W-1:0]  end_value;
  logic [LIMIT_W-1:0] max_payload;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   drain_n;
  logic [CNT_W-1:0]   drain_cnt;
  logic               rd_pend;
  logic [INDEX_W-1:0] rd_idx;
  logic               rd_last;
  logic [BYTE_W-1:0]  rd_data;
  logic [BYTE_W-1:0]  mem [MAX_DEPTH];

  logic               out_free;
  logic               rx_take;
  logic               issue;
  logic               move;
  logic               is_end;
  logic               over;
  logic               wr_en;
  logic [LIMIT_W-1:0] eff_limit;

  assign cfg.ready = 1'b1;

  assign out_free  = !res.valid || res.ready;
  assign rx.ready  = (st != S_DRAIN) && out_free;
  assign rx_take   = rx.valid && rx.ready;
  assign is_end    = (rx.rx_byte == end_value);
  assign eff_limit = (max_payload > LIMIT_W'(LIMIT_CAP)) ? LIMIT_W'(LIMIT_CAP) : max_payload;
  assign over      = (LIMIT_W'(count) >= eff_limit);
  assign wr_en     = rx_take && (st == S_FRAME) && !is_end && !over;
  assign issue     = (st == S_DRAIN) && (drain_cnt != drain_n) && (!rd_pend || out_free);
  assign move      = rd_pend && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_value <= START_RESET;
      end_value   <= END_RESET;
      max_payload <= LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_START_VALUE: start_value <= cfg.data;
        REG_END_VALUE:   end_value <= cfg.data;
        REG_MAX_PAYLOAD: max_payload <= cfg.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ADDR_W'(count)] <= rx.rx_byte;
    end
    if (issue) begin
      rd_data <= mem[ADDR_W'(drain_cnt)];
      rd_idx  <= INDEX_W'(drain_cnt);
      rd_last <= ((drain_cnt + CNT_W'(1)) == drain_n);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      count     <= '0;
      drain_n   <= '0;
      drain_cnt <= '0;
      rd_pend   <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      if (issue) begin
        drain_cnt <= drain_cnt + CNT_W'(1);
        rd_pend   <= 1'b1;
      end else if (move) begin
        rd_pend <= 1'b0;
      end
      if (move) begin
        res.valid        <= 1'b1;
        res.kind         <= KIND_PAYLOAD;
        res.payload_byte <= rd_data;
        res.byte_index   <= rd_idx;
        res.last         <= rd_last;
        if (rd_last) begin
          st <= S_IDLE;
        end
      end
      if (rx_take) begin
        case (st)
          S_IDLE: begin
            if (rx.rx_byte == start_value) begin
              st    <= S_FRAME;
              count <= '0;
            end
          end
          S_FRAME: begin
            if (is_end) begin
              count <= '0;
              if (count == '0) begin
                st               <= S_IDLE;
                res.valid        <= 1'b1;
                res.kind         <= KIND_EMPTY;
                res.payload_byte <= '0;
                res.byte_index   <= '0;
                res.last         <= 1'b1;
              end else begin
                st        <= S_DRAIN;
                drain_n   <= count;
                drain_cnt <= '0;
              end
            end else if (over) begin
              st               <= S_IDLE;
              count            <= '0;
              res.valid        <= 1'b1;
              res.kind         <= KIND_DROPPED;
              res.payload_byte <= '0;
              res.byte_index   <= '0;
              res.last         <= 1'b1;
            end else begin
              count <= count + CNT_W'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  a_read_only_in_drain: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (st == S_DRAIN))
    else $error("read in flight outside the drain");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(LIMIT_CAP))
    else $error("payload count beyond the store capacity");

  a_drain_bounded: assert property (@(posedge clk) disable iff (rst)
    (st == S_DRAIN) |-> (drain_cnt <= drain_n) && (drain_n != '0))
    else $error("drain counter out of range");

  a_last_ends_drain: assert property (@(posedge clk) disable iff (rst)
    (move && rd_last) |=> (st == S_IDLE) && !rd_pend)
    else $error("drain did not finish after the last byte");

  a_no_write_in_drain: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (st == S_FRAME) && !rd_pend)
    else $error("payload write overlaps the drain");

endmodule
